FILE: src/obn_pkg.sv
// Shared types, constants and arithmetic helpers for the orthonormal basis block.
`timescale 1ns / 1ps

package obn_pkg;

    // Width of one vector component; components are signed Q2.(CW-2).
    localparam int CW = 16;
    localparam int FRAC = CW - 2;
    // Reciprocal quotient bits, one divider stage per bit.
    localparam int NDIV = FRAC + 1;
    // Rounded product width, long product width, and saturation input width.
    localparam int WP = CW + 2;
    localparam int WL = 2 * CW + 2;
    localparam int WS = CW + 3;

    localparam logic signed [WS-1:0] SAT_MAX = {{(WS - CW + 1){1'b0}}, {(CW - 1){1'b1}}};
    localparam logic signed [WS-1:0] SAT_MIN = {{(WS - CW + 1){1'b1}}, {(CW - 1){1'b0}}};
    localparam logic signed [WS-1:0] ONE_S = {{(WS - FRAC - 1){1'b0}}, 1'b1, {FRAC{1'b0}}};
    localparam logic [WL-1:0] HALF_L = {{(WL - FRAC){1'b0}}, 1'b1, {(FRAC - 1){1'b0}}};

    typedef struct packed {
        logic signed [CW-1:0] normal_x;
        logic signed [CW-1:0] normal_y;
        logic signed [CW-1:0] normal_z;
    } t_normal;

    typedef struct packed {
        logic signed [CW-1:0] tangent_x;
        logic signed [CW-1:0] tangent_y;
        logic signed [CW-1:0] tangent_z;
        logic signed [CW-1:0] bitangent_x;
        logic signed [CW-1:0] bitangent_y;
        logic signed [CW-1:0] bitangent_z;
    } t_basis;

    // Partial state of the restoring reciprocal divider.
    typedef struct packed {
        logic [FRAC+1:0] rem;
        logic [FRAC:0]   num;
        logic [FRAC:0]   quo;
        logic [FRAC+1:0] dm;
    } t_div;

    // Divide by 2^FRAC, rounding to nearest with ties away from zero.
    function automatic logic signed [WP-1:0] scale_down(input logic signed [WL-1:0] v);
        logic [WL-1:0] mag;
        logic [WL-1:0] rnd;
        logic [WL-1:0] res;
        mag = v[WL-1] ? -v : v;
        rnd = (mag + HALF_L) >> FRAC;
        res = v[WL-1] ? -rnd : rnd;
        return res[WP-1:0];
    endfunction

    // Clamp to the signed component range.
    function automatic logic signed [CW-1:0] saturate(input logic signed [WS-1:0] v);
        logic signed [WS-1:0] c;
        c = v;
        if (v > SAT_MAX) begin
            c = SAT_MAX;
        end
        if (v < SAT_MIN) begin
            c = SAT_MIN;
        end
        return c[CW-1:0];
    endfunction

endpackage

FILE: src/obn_div_step.sv
// One restoring step of the reciprocal divider: shifts in a numerator bit, yields a quotient bit.
`timescale 1ns / 1ps

module obn_div_step (
    input  obn_pkg::t_div i_d,
    output obn_pkg::t_div o_d
);

    localparam int F = obn_pkg::FRAC;

    logic [F+2:0] trial;
    logic [F+2:0] diff;
    logic         ge;

    always_comb begin
        trial = {i_d.rem, i_d.num[F]};
        diff  = trial - {1'b0, i_d.dm};
        ge    = (trial >= {1'b0, i_d.dm});
        o_d.rem = ge ? diff[F+1:0] : trial[F+1:0];
        o_d.num = {i_d.num[F-1:0], 1'b0};
        o_d.quo = {i_d.quo[F-1:0], ge};
        o_d.dm  = i_d.dm;
    end

endmodule

FILE: src/orthonormal_basis_from_normal_top.sv
// Top level of the streaming orthonormal basis generator.
`timescale 1ns / 1ps

// This block takes one unit normal per transfer and returns the two tangent
// vectors that complete an orthonormal basis, using the branchless
// construction: sign is +1 for z > 0 and -1 otherwise, ta = -1/(sign + z),
// tb = x*y*ta. All values are signed Q2.14 at the default 16-bit component
// width; the reciprocal and every product are rounded to nearest (ties away
// from zero) and each output saturates to the component range. The pipeline
// accepts one item every cycle while no result is parked in the skid
// register. Its depth is set by the reciprocal, which is a restoring
// divider with one stage per quotient bit (FRAC + 1 stages), followed by a
// multiply stage, a rounding stage and a saturating output stage. A one-entry
// skid register sits at the output: when a result is not taken, it is parked
// there and the pipeline keeps moving for that cycle, then the whole pipeline
// holds until the parked result has been transferred. No result is ever
// dropped or repeated.

module orthonormal_basis_from_normal_top (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  obn_pkg::t_normal i_normal,
    output logic             o_valid,
    input  logic             i_ready,
    output obn_pkg::t_basis  o_basis
);

    localparam int CW   = obn_pkg::CW;
    localparam int F    = obn_pkg::FRAC;
    localparam int NDIV = obn_pkg::NDIV;
    localparam int WP   = obn_pkg::WP;
    localparam int WL   = obn_pkg::WL;
    localparam int WS   = obn_pkg::WS;
    // Input stage, divider stages, multiply, round, output.
    localparam int NS   = NDIV + 4;

    localparam logic signed [CW+1:0] ONE_D = {{(CW + 1 - F){1'b0}}, 1'b1, {F{1'b0}}};

    // Items carried alongside the divider after the square and cross
    // products have been rounded.
    typedef struct packed {
        logic signed [WP-1:0] xy_r;
        logic signed [WP-1:0] xx_r;
        logic signed [WP-1:0] yy_r;
        logic signed [CW-1:0] tz;
        logic signed [CW-1:0] bz;
        logic                 pos;
    } t_carry;

    // Input stage contents: raw products and the two outputs that need no
    // reciprocal.
    typedef struct packed {
        logic signed [2*CW-1:0] xy;
        logic signed [2*CW-1:0] xx;
        logic signed [2*CW-1:0] yy;
        logic signed [CW-1:0]   tz;
        logic signed [CW-1:0]   bz;
        logic                   pos;
    } t_stage0;

    typedef struct packed {
        logic signed [WL-1:0] tb;
        logic signed [WL-1:0] p;
        logic signed [WL-1:0] q;
        logic signed [CW-1:0] tz;
        logic signed [CW-1:0] bz;
        logic                 pos;
    } t_mul;

    typedef struct packed {
        logic signed [WP-1:0] tb;
        logic signed [WP-1:0] p;
        logic signed [WP-1:0] q;
        logic signed [CW-1:0] tz;
        logic signed [CW-1:0] bz;
        logic                 pos;
    } t_rnd;

    // Pipeline control. The whole pipeline advances unless a result is
    // parked in the skid register.
    logic [NS-1:0]   r_vld;
    logic            r_skid_v;
    logic            ce;
    logic            park;

    // Payload registers.
    t_stage0         r_s0;
    obn_pkg::t_div   r_div [0:NDIV];
    t_carry          r_car [1:NDIV];
    t_mul            r_mul;
    t_rnd            r_rnd;
    obn_pkg::t_basis r_out;
    obn_pkg::t_basis r_skid;

    // Next values.
    t_stage0         n_s0;
    obn_pkg::t_div   n_div [0:NDIV];
    t_carry          n_car1;
    t_mul            n_mul;
    t_rnd            n_rnd;
    obn_pkg::t_basis n_out;

    // Input stage helpers.
    logic signed [CW-1:0]    x;
    logic signed [CW-1:0]    y;
    logic signed [CW-1:0]    z;
    logic signed [WS-1:0]    xe;
    logic signed [WS-1:0]    ye;
    logic signed [CW+1:0]    ze;
    logic signed [CW+1:0]    dsum;
    logic [F+1:0]            dm;
    logic [2*F:0]            numer;
    logic signed [CW-1:0]    tam;

    // Output stage helpers.
    logic signed [WS-1:0]    pe;
    logic signed [WS-1:0]    tbe;
    logic signed [WS-1:0]    qone;

    assign ce      = !r_skid_v;
    assign o_ready = ce;
    assign park    = ce && r_vld[NS-1] && !i_ready;
    assign o_valid = r_skid_v || r_vld[NS-1];
    assign o_basis = r_skid_v ? r_skid : r_out;

    // Input stage: products, divisor setup, and the z outputs.
    always_comb begin
        x  = i_normal.normal_x;
        y  = i_normal.normal_y;
        z  = i_normal.normal_z;
        xe = {{(WS - CW){x[CW-1]}}, x};
        ye = {{(WS - CW){y[CW-1]}}, y};
        ze = {{2{z[CW-1]}}, z};

        n_s0.pos = (z > 0);
        n_s0.xy  = (2 * CW)'(x) * (2 * CW)'(y);
        n_s0.xx  = (2 * CW)'(x) * (2 * CW)'(x);
        n_s0.yy  = (2 * CW)'(y) * (2 * CW)'(y);
        n_s0.tz  = obn_pkg::saturate(n_s0.pos ? -xe : xe);
        n_s0.bz  = obn_pkg::saturate(-ye);

        // The divisor magnitude is z + 1 for positive z, else 1 - z.
        dsum  = n_s0.pos ? (ze + ONE_D) : (ONE_D - ze);
        dm    = dsum[F+1:0];
        numer = {1'b1, {(2 * F){1'b0}}} + {{F{1'b0}}, dm[F+1:1]};

        n_div[0].rem = {2'b00, numer[2*F:F+1]};
        n_div[0].num = numer[F:0];
        n_div[0].quo = '0;
        n_div[0].dm  = dm;
    end

    // First carry stage rounds the raw products.
    always_comb begin
        n_car1.xy_r = obn_pkg::scale_down({{(WL - 2 * CW){r_s0.xy[2*CW-1]}}, r_s0.xy});
        n_car1.xx_r = obn_pkg::scale_down({{(WL - 2 * CW){r_s0.xx[2*CW-1]}}, r_s0.xx});
        n_car1.yy_r = obn_pkg::scale_down({{(WL - 2 * CW){r_s0.yy[2*CW-1]}}, r_s0.yy});
        n_car1.tz   = r_s0.tz;
        n_car1.bz   = r_s0.bz;
        n_car1.pos  = r_s0.pos;
    end

    genvar k;
    generate
        for (k = 1; k <= NDIV; k++) begin : g_div
            obn_div_step u_step (
                .i_d (r_div[k-1]),
                .o_d (n_div[k])
            );

            always_ff @(posedge i_clk) begin
                if (ce) begin
                    r_div[k] <= n_div[k];
                end
            end

            if (k == 1) begin : g_first
                always_ff @(posedge i_clk) begin
                    if (ce) begin
                        r_car[k] <= n_car1;
                    end
                end
            end else begin : g_rest
                always_ff @(posedge i_clk) begin
                    if (ce) begin
                        r_car[k] <= r_car[k-1];
                    end
                end
            end
        end
    endgenerate

    // The signed reciprocal is -sign * tam, so sign folds into the final
    // combination and the multipliers see the unsigned magnitude.
    always_comb begin
        tam       = {1'b0, r_div[NDIV].quo};
        n_mul.tb  = WL'(r_car[NDIV].xy_r) * WL'(tam);
        n_mul.p   = WL'(r_car[NDIV].xx_r) * WL'(tam);
        n_mul.q   = WL'(r_car[NDIV].yy_r) * WL'(tam);
        n_mul.tz  = r_car[NDIV].tz;
        n_mul.bz  = r_car[NDIV].bz;
        n_mul.pos = r_car[NDIV].pos;
    end

    always_comb begin
        n_rnd.tb  = obn_pkg::scale_down(r_mul.tb);
        n_rnd.p   = obn_pkg::scale_down(r_mul.p);
        n_rnd.q   = obn_pkg::scale_down(r_mul.q);
        n_rnd.tz  = r_mul.tz;
        n_rnd.bz  = r_mul.bz;
        n_rnd.pos = r_mul.pos;
    end

    // With ta = -sign * tam: tangent = (1 - p, -tb, -sign x) and
    // bitangent = (-sign tb, sign (1 - q), -y), where p, q, tb use tam.
    always_comb begin
        pe   = {r_rnd.p[WP-1], r_rnd.p};
        tbe  = {r_rnd.tb[WP-1], r_rnd.tb};
        qone = obn_pkg::ONE_S - {r_rnd.q[WP-1], r_rnd.q};
        n_out.tangent_x   = obn_pkg::saturate(obn_pkg::ONE_S - pe);
        n_out.tangent_y   = obn_pkg::saturate(-tbe);
        n_out.tangent_z   = r_rnd.tz;
        n_out.bitangent_x = obn_pkg::saturate(r_rnd.pos ? -tbe : tbe);
        n_out.bitangent_y = obn_pkg::saturate(r_rnd.pos ? qone : -qone);
        n_out.bitangent_z = r_rnd.bz;
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_s0     <= n_s0;
            r_div[0] <= n_div[0];
            r_mul    <= n_mul;
            r_rnd    <= n_rnd;
            r_out    <= n_out;
        end
        if (park) begin
            r_skid <= r_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_skid_v <= 1'b0;
        end else begin
            if (r_skid_v) begin
                if (i_ready) begin
                    r_skid_v <= 1'b0;
                end
            end else begin
                r_vld <= {r_vld[NS-2:0], i_valid};
                if (park) begin
                    r_skid_v <= 1'b1;
                end
            end
        end
    end

`ifndef SYNTHESIS
    // An accepted input always occupies the first stage on the next cycle.
    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> r_vld[0])
        else $error("accepted input did not enter the pipeline");

    // While a result is parked, no stage may move.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |=> $stable(r_vld))
        else $error("pipeline advanced while the skid register was full");

    // A parked result that is not taken stays parked.
    a_skid_keep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_v && !i_ready) |=> (r_skid_v && $stable(r_skid)))
        else $error("parked result lost or changed");

    // The divider remainder stays below the divisor.
    a_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[NDIV] |-> (r_div[NDIV].rem < r_div[NDIV].dm))
        else $error("divider remainder out of range");
`endif

endmodule
